// ===== hdl/vmtc_pkg.sv =====
// Shared types, constants and helper functions of the video mode timing checker.
`default_nettype none
package vmtc_pkg;

  localparam int CLK_W = 22;
  localparam int T_W = 16;
  localparam int LR_W = 20;
  localparam int FR_W = 8;
  localparam int FLAG_W = 4;
  localparam int TF_W = 5;
  localparam int HZ_W = 32;
  localparam int FT_W = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 22;

  localparam int P_W = 32;
  localparam int LRP_W = 36;
  localparam int HV_W = 32;
  localparam int PO_W = 48;
  localparam int AD_W = 53;
  localparam int FH_W = 40;
  localparam int X_W = 38;
  localparam int Y_W = 27;
  localparam int DVR_W = 17;
  localparam int Q1_W = 22;
  localparam int KC_W = 23;
  localparam int Q2_W = 10;
  localparam int SCALE_W = 10;
  localparam logic [SCALE_W-1:0] KHZ_SCALE = 10'd1000;

  localparam int DIV_QBITS = 24;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STAGES = DIV_QBITS / DIV_STEPS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QIDX_W = 2;
  localparam int QCNT_W = 3;

  localparam int TIMING_BITS_DEFAULT = 16;

  localparam logic [LR_W-1:0] LINE_MIN_RESET = 20'd15000;
  localparam logic [LR_W-1:0] LINE_MAX_RESET = 20'd16500;
  localparam logic [FR_W-1:0] FIELD_MIN_RESET = 8'd47;
  localparam logic [FR_W-1:0] FIELD_MAX_RESET = 8'd63;
  localparam logic [T_W-1:0] WIDTH_RESET = 16'd1280;
  localparam logic [T_W-1:0] HEIGHT_RESET = 16'd640;
  localparam logic [CLK_W-1:0] CLK_MIN_RESET = 22'd2000;
  localparam logic [CLK_W-1:0] CLK_MAX_RESET = 22'd32000;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_GEOMETRY   = 3'd1,
    ST_LINE_RATE  = 3'd2,
    ST_FIELD_RATE = 3'd3,
    ST_TOO_BIG    = 3'd4,
    ST_CLOCK      = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_MIN  = 3'd0,
    CFG_LINE_MAX  = 3'd1,
    CFG_FIELD_MIN = 3'd2,
    CFG_FIELD_MAX = 3'd3,
    CFG_WIDTH     = 3'd4,
    CFG_HEIGHT    = 3'd5,
    CFG_CLK_MIN   = 3'd6,
    CFG_CLK_MAX   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [CLK_W-1:0]  pixel_clock_khz;
    logic [T_W-1:0]    h_display;
    logic [T_W-1:0]    h_sync_start;
    logic [T_W-1:0]    h_sync_end;
    logic [T_W-1:0]    h_line_total;
    logic [T_W-1:0]    v_display;
    logic [T_W-1:0]    v_sync_start;
    logic [T_W-1:0]    v_sync_end;
    logic [T_W-1:0]    v_frame_total;
    logic [FLAG_W-1:0] request_flags;
  } modeline_t;

  typedef struct packed {
    status_t          status;
    logic [T_W-1:0]   h_sync_len;
    logic [T_W-1:0]   h_back_porch;
    logic [T_W-1:0]   h_active;
    logic [T_W-1:0]   h_front_porch;
    logic [T_W-1:0]   v_sync_len;
    logic [T_W-1:0]   v_back_porch;
    logic [T_W-1:0]   v_active;
    logic [T_W-1:0]   v_front_porch;
    logic [FT_W-1:0]  field_total_lines;
    logic [TF_W-1:0]  timing_flags;
    logic [HZ_W-1:0]  pixel_clock_hz;
  } timing_t;

  typedef struct packed {
    logic [LR_W-1:0]  line_rate_min_hz;
    logic [LR_W-1:0]  line_rate_max_hz;
    logic [FR_W-1:0]  field_rate_min_hz;
    logic [FR_W-1:0]  field_rate_max_hz;
    logic [T_W-1:0]   width_limit;
    logic [T_W-1:0]   height_limit;
    logic [CLK_W-1:0] pixel_clock_min_khz;
    logic [CLK_W-1:0] pixel_clock_max_khz;
  } cfg_regs_t;

  typedef struct packed {
    modeline_t        mode;
    logic [P_W-1:0]   p;
    logic [LRP_W-1:0] a;
    logic [LRP_W-1:0] b;
    logic [HV_W-1:0]  hv;
    logic             conv;
    status_t          pre;
  } front_item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } queue_stat_t;

  typedef struct packed {
    front_item_t      it;
    logic [PO_W-1:0]  po;
    logic [AD_W-1:0]  ad;
    logic [AD_W-1:0]  bd;
    logic [FH_W-1:0]  fmin_h;
    logic [FH_W-1:0]  fmax_h;
    logic [X_W-1:0]   x;
    logic [T_W-1:0]   vsy;
    logic [T_W-1:0]   vbp;
    logic [T_W-1:0]   vact;
    logic [T_W-1:0]   vfp;
    logic [T_W-1:0]   vtf;
    logic             intl;
  } back_s1_t;

  typedef struct packed {
    status_t          pre;
    logic             conv;
    logic             line_bad;
    logic             field_bad;
    logic [CLK_W-1:0] khz;
    logic [P_W-1:0]   p;
    logic [T_W-1:0]   vt;
    logic [DVR_W-1:0] d;
    logic [T_W-1:0]   h_sync_len;
    logic [T_W-1:0]   h_back_porch;
    logic [T_W-1:0]   h_active;
    logic [T_W-1:0]   h_front_porch;
    logic [T_W-1:0]   v_sync_len;
    logic [T_W-1:0]   v_back_porch;
    logic [T_W-1:0]   v_active;
    logic [T_W-1:0]   v_front_porch;
    logic [FT_W-1:0]  field_total;
    logic [TF_W-1:0]  tflags;
    logic [Q1_W-1:0]  q1;
    logic [KC_W-1:0]  kc;
  } back_ctx_t;

  typedef struct packed {
    logic [DVR_W-1:0]     rem;
    logic [DIV_QBITS-1:0] dvd;
  } divstate_t;

  // Several restoring division steps; the quotient shifts into the dividend word.
  function automatic divstate_t div_stage(input divstate_t s, input logic [DVR_W-1:0] d);
    divstate_t r;
    logic [DVR_W:0] t;
    r = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r.rem, r.dvd[DIV_QBITS-1]};
      if (t >= {1'b0, d}) begin
        r.rem = DVR_W'(t - {1'b0, d});
        r.dvd = {r.dvd[DIV_QBITS-2:0], 1'b1};
      end else begin
        r.rem = t[DVR_W-1:0];
        r.dvd = {r.dvd[DIV_QBITS-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/vmtc_front.sv =====
// Front end: takes modelines, forms the rate products and classifies each item.
`default_nettype none
module vmtc_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  mode_valid,
  output logic                       mode_stall,
  input  wire vmtc_pkg::modeline_t   mode,
  input  wire vmtc_pkg::cfg_regs_t   cfg,
  input  wire logic                  q_full,
  output logic                       push,
  output vmtc_pkg::front_item_t      push_item
);
  import vmtc_pkg::*;

  logic             fv;
  modeline_t        m;
  logic [P_W-1:0]   p;
  logic [LRP_W-1:0] a;
  logic [LRP_W-1:0] b;
  logic [HV_W-1:0]  hv;
  logic             accept;
  logic             geo_bad;
  logic             size_bad;

  assign mode_stall = fv && q_full;
  assign accept = mode_valid && !mode_stall;
  assign push = fv && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m <= mode;
      p <= P_W'(P_W'(mode.pixel_clock_khz) * P_W'(KHZ_SCALE));
      a <= LRP_W'(cfg.line_rate_min_hz) * LRP_W'(mode.h_line_total);
      b <= LRP_W'(cfg.line_rate_max_hz) * LRP_W'(mode.h_line_total);
      hv <= HV_W'(mode.h_line_total) * HV_W'(mode.v_frame_total);
    end
  end

  always_comb begin
    geo_bad = (m.h_display == '0) || (m.v_display == '0) || (m.pixel_clock_khz == '0) ||
              (m.h_display > m.h_sync_start) || (m.h_sync_start > m.h_sync_end) ||
              (m.h_sync_end > m.h_line_total) || (m.v_display > m.v_sync_start) ||
              (m.v_sync_start > m.v_sync_end) || (m.v_sync_end > m.v_frame_total);
    size_bad = (m.h_display > cfg.width_limit) || (m.v_display > cfg.height_limit);
    push_item.mode = m;
    push_item.p = p;
    push_item.a = a;
    push_item.b = b;
    push_item.hv = hv;
    push_item.conv = !m.request_flags[0] && ({4'b0, p} > b) &&
                     ({5'b0, p} >= {a, 1'b0}) && ({5'b0, p} <= {b, 1'b0});
    if (geo_bad) begin
      push_item.pre = ST_GEOMETRY;
    end else if (size_bad) begin
      push_item.pre = ST_TOO_BIG;
    end else begin
      push_item.pre = ST_OK;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/vmtc_queue.sv =====
// Short queue of classified items between the front end and the back end.
`default_nettype none
module vmtc_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire vmtc_pkg::front_item_t  push_item,
  input  wire logic                   pop,
  output vmtc_pkg::front_item_t       head,
  output vmtc_pkg::queue_stat_t       stat
);
  import vmtc_pkg::*;

  front_item_t       mem [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wp;
  logic [QIDX_W-1:0] rp;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= QIDX_W'(wp + 1'b1);
      end
      if (pop) begin
        rp <= QIDX_W'(rp + 1'b1);
      end
      if (push && !pop) begin
        count <= QCNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= QCNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_item;
    end
  end

  assign head = mem[rp];
  assign stat.count = count;
  assign stat.full = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule
`default_nettype wire

// ===== hdl/vmtc_back.sv =====
// Back end: rate checks, clock re-solving dividers and per-field timing.
`default_nettype none
module vmtc_back #(
  parameter int TIMING_BITS = vmtc_pkg::TIMING_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire vmtc_pkg::front_item_t  head,
  input  wire logic                   q_empty,
  input  wire vmtc_pkg::cfg_regs_t    cfg,
  output logic                        pop,
  output logic                        timing_valid,
  input  wire logic                   timing_stall,
  output vmtc_pkg::timing_t           timing
);
  import vmtc_pkg::*;

  localparam int NV = 2 * DIV_STAGES + 5;
  localparam logic [T_W-1:0] TMASK = T_W'((32'd1 << TIMING_BITS) - 1);

  logic [NV-1:0] vld;
  logic          en;

  back_s1_t  s1_next;
  back_s1_t  s1;
  back_ctx_t s2_next;
  divstate_t s2_div_next;
  back_ctx_t s2;
  divstate_t s2_div;
  back_ctx_t a_ctx [DIV_STAGES];
  divstate_t a_div [DIV_STAGES];
  back_ctx_t y_next;
  divstate_t y_div_next;
  back_ctx_t y_ctx;
  divstate_t y_div;
  back_ctx_t b_ctx [DIV_STAGES];
  divstate_t b_div [DIV_STAGES];
  back_ctx_t hz_ctx;
  logic [HZ_W-1:0] hz;
  timing_t   out_next;

  logic [T_W-1:0]   odd;
  logic [T_W-1:0]   vtot;
  logic [FT_W-1:0]  vsum;
  logic [FT_W-1:0]  vtf18;
  logic [FT_W-1:0]  vbp_adj;
  logic [P_W:0]     mp;
  logic [DVR_W-1:0] r1;
  logic [Y_W-1:0]   y;
  logic [KC_W-1:0]  kclk;
  logic             clock_bad;
  status_t          st;

  assign en = !vld[NV-1] || !timing_stall;
  assign pop = en && !q_empty;
  assign timing_valid = vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], !q_empty};
    end
  end

  always_comb begin
    odd = {head.mode.v_frame_total[T_W-1:1], 1'b1};
    vtot = head.conv ? odd : head.mode.v_frame_total;
    s1_next.it = head;
    s1_next.intl = head.mode.request_flags[0] | head.conv;
    s1_next.po = PO_W'(head.p) * PO_W'(odd);
    s1_next.ad = AD_W'(head.a) * AD_W'({head.mode.v_frame_total, 1'b0});
    s1_next.bd = AD_W'(head.b) * AD_W'({head.mode.v_frame_total, 1'b0});
    s1_next.fmin_h = FH_W'(cfg.field_rate_min_hz) * FH_W'(head.hv);
    s1_next.fmax_h = FH_W'(cfg.field_rate_max_hz) * FH_W'(head.hv);
    s1_next.x = X_W'(head.mode.pixel_clock_khz) * X_W'(odd);
    if (s1_next.intl) begin
      s1_next.vsy = T_W'(head.mode.v_sync_end - head.mode.v_sync_start) >> 1;
      s1_next.vbp = T_W'(vtot - head.mode.v_sync_end) >> 1;
      s1_next.vfp = T_W'(head.mode.v_sync_start - head.mode.v_display) >> 1;
      s1_next.vact = head.mode.v_display >> 1;
      s1_next.vtf = T_W'(vtot - 1'b1) >> 1;
      if (s1_next.vsy == '0) begin
        s1_next.vsy = T_W'(1);
      end
    end else begin
      s1_next.vsy = T_W'(head.mode.v_sync_end - head.mode.v_sync_start);
      s1_next.vbp = T_W'(head.mode.v_frame_total - head.mode.v_sync_end);
      s1_next.vfp = T_W'(head.mode.v_sync_start - head.mode.v_display);
      s1_next.vact = head.mode.v_display;
      s1_next.vtf = head.mode.v_frame_total;
    end
  end

  always_comb begin
    vsum = FT_W'(s1.vsy) + FT_W'(s1.vbp) + FT_W'(s1.vact) + FT_W'(s1.vfp);
    vtf18 = FT_W'(s1.vtf);
    vbp_adj = FT_W'(s1.vbp);
    if (vtf18 > vsum) begin
      vbp_adj = FT_W'(s1.vbp) + (vtf18 - vsum);
    end else if (vtf18 < vsum && FT_W'(s1.vbp) > (vsum - vtf18)) begin
      vbp_adj = FT_W'(s1.vbp) - (vsum - vtf18);
    end
    mp = s1.it.mode.request_flags[0] ? {s1.it.p, 1'b0} : {1'b0, s1.it.p};
    s2_next = '0;
    s2_next.pre = s1.it.pre;
    s2_next.conv = s1.it.conv;
    if (s1.it.conv) begin
      s2_next.line_bad = (s1.po < PO_W'(s1.ad)) && (s1.ad[AD_W-1:PO_W] == '0)
                         || (s1.ad[AD_W-1:PO_W] != '0)
                         || ({5'b0, s1.po} > s1.bd);
    end else begin
      s2_next.line_bad = ({4'b0, s1.it.p} < s1.it.a) || ({4'b0, s1.it.p} > s1.it.b);
    end
    s2_next.field_bad = (FH_W'(mp) < s1.fmin_h) || (FH_W'(mp) > s1.fmax_h);
    s2_next.khz = s1.it.mode.pixel_clock_khz;
    s2_next.p = s1.it.p;
    s2_next.vt = s1.it.mode.v_frame_total;
    s2_next.d = {s1.it.mode.v_frame_total, 1'b0};
    s2_next.h_sync_len = T_W'(s1.it.mode.h_sync_end - s1.it.mode.h_sync_start) & TMASK;
    s2_next.h_back_porch = T_W'(s1.it.mode.h_line_total - s1.it.mode.h_sync_end) & TMASK;
    s2_next.h_active = s1.it.mode.h_display & TMASK;
    s2_next.h_front_porch = T_W'(s1.it.mode.h_sync_start - s1.it.mode.h_display) & TMASK;
    s2_next.v_sync_len = s1.vsy & TMASK;
    s2_next.v_back_porch = vbp_adj[T_W-1:0] & TMASK;
    s2_next.v_active = s1.vact & TMASK;
    s2_next.v_front_porch = s1.vfp & TMASK;
    s2_next.field_total = FT_W'(s1.vsy) + FT_W'(vbp_adj[T_W-1:0]) + FT_W'(s1.vact) +
                          FT_W'(s1.vfp);
    s2_next.tflags = {s1.it.conv, s1.it.mode.request_flags[3:1], s1.intl};
    s2_div_next.rem = DVR_W'(s1.x[X_W-1:DIV_QBITS]);
    s2_div_next.dvd = s1.x[DIV_QBITS-1:0];
  end

  always_comb begin
    r1 = a_div[DIV_STAGES-1].rem;
    y_next = a_ctx[DIV_STAGES-1];
    y_next.q1 = a_div[DIV_STAGES-1].dvd[Q1_W-1:0];
    y_next.kc = KC_W'(y_next.q1) + KC_W'(r1 >= {1'b0, y_next.vt});
    y = Y_W'(Y_W'(r1) * Y_W'(KHZ_SCALE)) + Y_W'(y_next.vt);
    y_div_next.rem = DVR_W'(y[Y_W-1:DIV_QBITS]);
    y_div_next.dvd = y[DIV_QBITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s2_div <= s2_div_next;
      a_ctx[0] <= s2;
      a_div[0] <= div_stage(s2_div, s2.d);
      for (int i = 1; i < DIV_STAGES; i++) begin
        a_ctx[i] <= a_ctx[i-1];
        a_div[i] <= div_stage(a_div[i-1], a_ctx[i-1].d);
      end
      y_ctx <= y_next;
      y_div <= y_div_next;
      b_ctx[0] <= y_ctx;
      b_div[0] <= div_stage(y_div, y_ctx.d);
      for (int i = 1; i < DIV_STAGES; i++) begin
        b_ctx[i] <= b_ctx[i-1];
        b_div[i] <= div_stage(b_div[i-1], b_ctx[i-1].d);
      end
      hz_ctx <= b_ctx[DIV_STAGES-1];
      hz <= HZ_W'(HZ_W'(b_ctx[DIV_STAGES-1].q1) * HZ_W'(KHZ_SCALE)) +
            HZ_W'(b_div[DIV_STAGES-1].dvd[Q2_W-1:0]);
      timing <= out_next;
    end
  end

  always_comb begin
    kclk = hz_ctx.conv ? hz_ctx.kc : KC_W'(hz_ctx.khz);
    clock_bad = (kclk < KC_W'(cfg.pixel_clock_min_khz)) ||
                (kclk > KC_W'(cfg.pixel_clock_max_khz));
    if (hz_ctx.pre != ST_OK) begin
      st = hz_ctx.pre;
    end else if (clock_bad) begin
      st = ST_CLOCK;
    end else if (hz_ctx.line_bad) begin
      st = ST_LINE_RATE;
    end else if (hz_ctx.field_bad) begin
      st = ST_FIELD_RATE;
    end else begin
      st = ST_OK;
    end
    out_next = '0;
    out_next.status = st;
    if (st == ST_OK) begin
      out_next.h_sync_len = hz_ctx.h_sync_len;
      out_next.h_back_porch = hz_ctx.h_back_porch;
      out_next.h_active = hz_ctx.h_active;
      out_next.h_front_porch = hz_ctx.h_front_porch;
      out_next.v_sync_len = hz_ctx.v_sync_len;
      out_next.v_back_porch = hz_ctx.v_back_porch;
      out_next.v_active = hz_ctx.v_active;
      out_next.v_front_porch = hz_ctx.v_front_porch;
      out_next.field_total_lines = hz_ctx.field_total;
      out_next.timing_flags = hz_ctx.tflags;
      out_next.pixel_clock_hz = hz_ctx.conv ? hz : hz_ctx.p;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/video_mode_timing_check_core.sv =====
// Top level of the video mode timing checker: configuration registers and the pipeline.
`default_nettype none
// One modeline is accepted per cycle and one result is delivered per cycle when the output
// is not stalled. Each item passes one front-end register, one queue slot and a
// 17-stage back end, most of which is the two pipelined restoring dividers (four quotient
// bits per stage) that re-solve the pixel clock of a mode converted to interlaced. The
// front end keeps accepting while the four-entry queue has room. The configuration port
// is always ready; registers should be written only while no item is in flight.
module video_mode_timing_check_core #(
  parameter int TIMING_BITS = vmtc_pkg::TIMING_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              mode_valid,
  output logic                                   mode_stall,
  input  wire vmtc_pkg::modeline_t               mode,
  output logic                                   timing_valid,
  input  wire logic                              timing_stall,
  output vmtc_pkg::timing_t                      timing,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [vmtc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [vmtc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import vmtc_pkg::*;

  cfg_regs_t   cfg;
  logic        push;
  front_item_t push_item;
  front_item_t head;
  queue_stat_t qstat;
  logic        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_rate_min_hz <= LINE_MIN_RESET;
      cfg.line_rate_max_hz <= LINE_MAX_RESET;
      cfg.field_rate_min_hz <= FIELD_MIN_RESET;
      cfg.field_rate_max_hz <= FIELD_MAX_RESET;
      cfg.width_limit <= WIDTH_RESET;
      cfg.height_limit <= HEIGHT_RESET;
      cfg.pixel_clock_min_khz <= CLK_MIN_RESET;
      cfg.pixel_clock_max_khz <= CLK_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LINE_MIN: cfg.line_rate_min_hz <= cfg_data[LR_W-1:0];
        CFG_LINE_MAX: cfg.line_rate_max_hz <= cfg_data[LR_W-1:0];
        CFG_FIELD_MIN: cfg.field_rate_min_hz <= cfg_data[FR_W-1:0];
        CFG_FIELD_MAX: cfg.field_rate_max_hz <= cfg_data[FR_W-1:0];
        CFG_WIDTH: cfg.width_limit <= cfg_data[T_W-1:0];
        CFG_HEIGHT: cfg.height_limit <= cfg_data[T_W-1:0];
        CFG_CLK_MIN: cfg.pixel_clock_min_khz <= cfg_data[CLK_W-1:0];
        CFG_CLK_MAX: cfg.pixel_clock_max_khz <= cfg_data[CLK_W-1:0];
        default: ;
      endcase
    end
  end

  vmtc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode_valid (mode_valid),
    .mode_stall (mode_stall),
    .mode       (mode),
    .cfg        (cfg),
    .q_full     (qstat.full),
    .push       (push),
    .push_item  (push_item)
  );

  vmtc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  vmtc_back #(
    .TIMING_BITS (TIMING_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (qstat.empty),
    .cfg          (cfg),
    .pop          (pop),
    .timing_valid (timing_valid),
    .timing_stall (timing_stall),
    .timing       (timing)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    mode_stall |-> qstat.full)
    else $error("input stalled while the queue has room");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    timing_valid && timing.status != ST_OK |->
      timing.pixel_clock_hz == '0 && timing.field_total_lines == '0)
    else $error("rejected item carries timing");

  a_conv_interlaced: assert property (@(posedge clk) disable iff (rst)
    timing_valid && timing.timing_flags[4] |-> timing.timing_flags[0])
    else $error("converted item not marked interlaced");

endmodule
`default_nettype wire
